/* hw/rtl/drive_command_arbiter_top_defines.svh */
// Assertion macros for the drive command arbiter.
`ifndef DRIVE_COMMAND_ARBITER_TOP_DEFINES_SVH
`define DRIVE_COMMAND_ARBITER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define DCA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("drive command arbiter assertion failed");
`define DCA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("drive command arbiter reset assertion failed");
`else
`define DCA_ASSERT(lbl, prop)
`define DCA_ASSERT_RST(lbl, prop)
`endif
`endif

/* hw/rtl/dca_pkg.sv */
// Types and constants shared by the drive command arbiter modules.
`default_nettype none
package dca_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [2:0] CFG_THR_ON      = 3'd0;
  localparam logic [2:0] CFG_THR_BRAKE   = 3'd1;
  localparam logic [2:0] CFG_STEER_ACT   = 3'd2;
  localparam logic [2:0] CFG_STEER_DEACT = 3'd3;
  localparam logic [2:0] CFG_NEUTRAL_THR = 3'd4;
  localparam logic [2:0] CFG_CENTER_STR  = 3'd5;
  localparam logic [2:0] CFG_QUIET_LIMIT = 3'd6;
  localparam logic [2:0] CFG_FWD_GAIN    = 3'd7;

  localparam logic [11:0] STEER_UPPER_LIMIT  = 12'd2400;
  localparam logic [12:0] CENTER_HALF_WINDOW = 13'd50;

  typedef enum logic [2:0] {
    ACT_HOLD   = 3'd0,
    ACT_HOST   = 3'd1,
    ACT_BRAKE  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_RC_FWD = 3'd4
  } action_t;

  typedef struct packed {
    logic        opcode;
    logic [11:0] throttle_us;
    logic [11:0] steer_us;
    logic [7:0]  speed_code;
    logic [7:0]  angle_code;
    logic [7:0]  light_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  drive_action;
    logic [7:0]  out_speed_code;
    logic [7:0]  out_angle_code;
    logic [11:0] esc_pulse_us;
    logic [11:0] servo_pulse_us;
    logic [7:0]  light_out;
    logic        rc_active;
    logic        rc_brake;
    logic        led_on;
  } out_item_t;

  typedef struct packed {
    logic [11:0] throttle_on_level;
    logic [11:0] throttle_brake_level;
    logic [11:0] steer_activate_level;
    logic [11:0] steer_deactivate_level;
    logic [11:0] neutral_throttle_us;
    logic [11:0] centered_steer_us;
    logic [15:0] quiet_tick_limit;
    logic [7:0]  forward_gain_q8;
  } cfg_regs_t;

endpackage
`default_nettype wire

/* hw/rtl/dca_cfg.sv */
// Configuration register file of the drive command arbiter.
`default_nettype none
module dca_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [2:0]        wr_index,
  input  wire logic [15:0]       wr_data,
  output dca_pkg::cfg_regs_t     cfg
);

  dca_pkg::cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        dca_pkg::CFG_THR_ON:      cfg_nxt.throttle_on_level      = wr_data[11:0];
        dca_pkg::CFG_THR_BRAKE:   cfg_nxt.throttle_brake_level   = wr_data[11:0];
        dca_pkg::CFG_STEER_ACT:   cfg_nxt.steer_activate_level   = wr_data[11:0];
        dca_pkg::CFG_STEER_DEACT: cfg_nxt.steer_deactivate_level = wr_data[11:0];
        dca_pkg::CFG_NEUTRAL_THR: cfg_nxt.neutral_throttle_us    = wr_data[11:0];
        dca_pkg::CFG_CENTER_STR:  cfg_nxt.centered_steer_us      = wr_data[11:0];
        dca_pkg::CFG_QUIET_LIMIT: cfg_nxt.quiet_tick_limit       = wr_data;
        dca_pkg::CFG_FWD_GAIN:    cfg_nxt.forward_gain_q8        = wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_on_level      <= 12'd1000;
      cfg_r.throttle_brake_level   <= 12'd1300;
      cfg_r.steer_activate_level   <= 12'd1900;
      cfg_r.steer_deactivate_level <= 12'd1100;
      cfg_r.neutral_throttle_us    <= 12'd1500;
      cfg_r.centered_steer_us      <= 12'd1500;
      cfg_r.quiet_tick_limit       <= 16'd10;
      cfg_r.forward_gain_q8        <= 8'd51;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* hw/rtl/dca_core.sv */
// Arbitration state and single-pass decision logic for one item.
`default_nettype none
module dca_core #(
  parameter int MODE_HOLD_TICKS     = 20,
  parameter int CENTER_WINDOW_TICKS = 50,
  parameter int STOP_SPEED_CODE     = 0,
  parameter int CENTER_ANGLE_CODE   = 90,
  parameter int BACKWARD_GAIN_Q8    = 205
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_fire,
  input  wire dca_pkg::in_item_t  item,
  input  wire dca_pkg::cfg_regs_t cfg,
  output dca_pkg::out_item_t      result
);

  localparam logic [7:0] HOLD_TICKS = 8'(MODE_HOLD_TICKS);
  localparam logic [7:0] WIN_TICKS  = 8'(CENTER_WINDOW_TICKS);
  localparam logic [7:0] STOP_SPEED = 8'(STOP_SPEED_CODE);
  localparam logic [7:0] CENTER_ANG = 8'(CENTER_ANGLE_CODE);
  localparam logic [7:0] BACK_GAIN  = 8'(BACKWARD_GAIN_Q8);

  typedef struct packed {
    logic [7:0]  stored_speed;
    logic [7:0]  stored_angle;
    logic [7:0]  stored_lights;
    logic        data_fresh;
    logic [15:0] quiet_ticks;
    logic [7:0]  above_count;
    logic [7:0]  below_count;
    logic [7:0]  center_window;
    logic        rc_mode_flag;
    logic        blink_phase;
    logic        led_level;
  } state_t;

  state_t st_r, st_nxt;

  logic [11:0] thr;
  logic [11:0] steer;
  logic        thr_on;
  logic        near_center;
  logic        thr_up;
  logic [11:0] thr_diff;
  logic [7:0]  gain_sel;
  logic [19:0] gain_prod;
  logic [11:0] esc_pulse;

  assign thr   = item.throttle_us;
  assign steer = item.steer_us;
  assign thr_on = thr > cfg.throttle_on_level;
  assign near_center = (({1'b0, steer} + dca_pkg::CENTER_HALF_WINDOW) >
                        {1'b0, cfg.centered_steer_us}) &&
                       ({1'b0, steer} <
                        ({1'b0, cfg.centered_steer_us} + dca_pkg::CENTER_HALF_WINDOW));

  // Throttle attenuation around neutral: one shared multiplier, gain by direction.
  assign thr_up   = thr > cfg.neutral_throttle_us;
  assign thr_diff = thr_up ? (thr - cfg.neutral_throttle_us)
                           : (cfg.neutral_throttle_us - thr);
  assign gain_sel = thr_up ? cfg.forward_gain_q8 : BACK_GAIN;
  assign gain_prod = thr_diff * gain_sel;
  assign esc_pulse = thr_up ? (cfg.neutral_throttle_us + gain_prod[19:8])
                            : (cfg.neutral_throttle_us - gain_prod[19:8]);

  always_comb begin
    st_nxt = st_r;
    result = '0;
    if (item.opcode == dca_pkg::OP_LOAD) begin
      st_nxt.stored_speed  = item.speed_code;
      st_nxt.stored_angle  = item.angle_code;
      st_nxt.stored_lights = item.light_bits;
      st_nxt.data_fresh    = 1'b1;
    end else begin
      if (thr_on) begin
        st_nxt.led_level = st_r.rc_mode_flag;
        if (st_r.center_window == 8'd0) begin
          if (!st_r.rc_mode_flag && steer > cfg.steer_activate_level &&
              steer < dca_pkg::STEER_UPPER_LIMIT) begin
            if (st_r.above_count < HOLD_TICKS) begin
              st_nxt.above_count = st_r.above_count + 8'd1;
            end else begin
              st_nxt.center_window = WIN_TICKS;
            end
          end else if (st_r.rc_mode_flag && steer < cfg.steer_deactivate_level) begin
            if (st_r.below_count < HOLD_TICKS) begin
              st_nxt.below_count = st_r.below_count + 8'd1;
            end else begin
              st_nxt.center_window = WIN_TICKS;
            end
          end
        end else begin
          st_nxt.above_count = 8'd0;
          st_nxt.below_count = 8'd0;
          st_nxt.blink_phase = !st_r.blink_phase;
          st_nxt.led_level   = !st_r.blink_phase;
          if (near_center) begin
            st_nxt.rc_mode_flag  = !st_r.rc_mode_flag;
            st_nxt.center_window = 8'd0;
          end else begin
            st_nxt.center_window = st_r.center_window - 8'd1;
          end
        end
        if (steer >= cfg.steer_deactivate_level) begin
          st_nxt.below_count = 8'd0;
        end
        if (steer <= cfg.steer_activate_level) begin
          st_nxt.above_count = 8'd0;
        end
      end

      if (thr_on && st_nxt.rc_mode_flag) begin
        result.drive_action   = dca_pkg::ACT_RC_FWD;
        result.esc_pulse_us   = esc_pulse;
        result.servo_pulse_us = steer;
        result.rc_active      = 1'b1;
      end else if (thr >= cfg.throttle_on_level && thr <= cfg.throttle_brake_level) begin
        result.drive_action   = dca_pkg::ACT_BRAKE;
        result.out_speed_code = STOP_SPEED;
        result.out_angle_code = st_r.stored_angle;
        result.rc_brake       = 1'b1;
      end else if (st_r.data_fresh) begin
        result.drive_action   = dca_pkg::ACT_HOST;
        result.out_speed_code = st_r.stored_speed;
        result.out_angle_code = st_r.stored_angle;
        result.light_out      = st_r.stored_lights;
        st_nxt.data_fresh     = 1'b0;
        st_nxt.quiet_ticks    = 16'd0;
      end else if (st_r.quiet_ticks > cfg.quiet_tick_limit) begin
        result.drive_action   = dca_pkg::ACT_STOP;
        result.out_speed_code = STOP_SPEED;
        result.out_angle_code = CENTER_ANG;
        st_nxt.stored_speed   = STOP_SPEED;
        st_nxt.stored_angle   = CENTER_ANG;
      end else begin
        result.drive_action = dca_pkg::ACT_HOLD;
        if (st_r.quiet_ticks != 16'hFFFF) begin
          st_nxt.quiet_ticks = st_r.quiet_ticks + 16'd1;
        end
      end
      result.led_on = st_nxt.led_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.stored_speed  <= STOP_SPEED;
      st_r.stored_angle  <= CENTER_ANG;
      st_r.stored_lights <= 8'd0;
      st_r.data_fresh    <= 1'b0;
      st_r.quiet_ticks   <= 16'd0;
      st_r.above_count   <= 8'd0;
      st_r.below_count   <= 8'd0;
      st_r.center_window <= 8'd0;
      st_r.rc_mode_flag  <= 1'b0;
      st_r.blink_phase   <= 1'b0;
      st_r.led_level     <= 1'b0;
    end else if (item_fire) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/drive_command_arbiter_top.sv */
// Drive command arbiter top level: input register, decision logic, result register.
// A tick item passes through the input register and then the result register; a load
// item gives no result and updates the stored host data in the cycle after accept.
// Throughput: one item per cycle, limited only by the single result register draining.
// Reset: synchronous active-low rst_n clears both valid flags, the arbitration
// state and the configuration registers to their documented defaults.
`default_nettype none
`include "drive_command_arbiter_top_defines.svh"
module drive_command_arbiter_top #(
  parameter int MODE_HOLD_TICKS     = 20,
  parameter int CENTER_WINDOW_TICKS = 50,
  parameter int STOP_SPEED_CODE     = 0,
  parameter int CENTER_ANGLE_CODE   = 90,
  parameter int BACKWARD_GAIN_Q8    = 205
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // item input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dca_pkg::in_item_t in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dca_pkg::out_item_t     out_data,
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  dca_pkg::cfg_regs_t cfg;
  dca_pkg::in_item_t  item_r;
  dca_pkg::out_item_t out_r;
  dca_pkg::out_item_t result;
  logic               item_vld_r;
  logic               out_vld_r;
  logic               item_vld_nxt;
  logic               out_vld_nxt;
  logic               item_fire;
  logic               tick_fire;

  // Config writes take effect in the cycle after cfg_valid; always ready.
  assign cfg_ready = 1'b1;

  dca_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held item when it is a load (no result slot needed) or the
  // result register is empty or being drained this cycle.
  assign item_fire = item_vld_r &&
                     (item_r.opcode == dca_pkg::OP_LOAD || !out_vld_r || out_ready);
  assign tick_fire = item_fire && item_r.opcode == dca_pkg::OP_TICK;

  // Take a new item whenever the input register empties this cycle.
  assign in_ready = !item_vld_r || item_fire;

  dca_core #(
    .MODE_HOLD_TICKS     (MODE_HOLD_TICKS),
    .CENTER_WINDOW_TICKS (CENTER_WINDOW_TICKS),
    .STOP_SPEED_CODE     (STOP_SPEED_CODE),
    .CENTER_ANGLE_CODE   (CENTER_ANGLE_CODE),
    .BACKWARD_GAIN_Q8    (BACKWARD_GAIN_Q8)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .item      (item_r),
    .cfg       (cfg),
    .result    (result)
  );

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_ready) begin
      item_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r;
    if (tick_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
    if (tick_fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A tick that advances always fills the result register.
  `DCA_ASSERT(a_tick_fills_result, tick_fire |=> out_vld_r)
  // A load never creates a result; the register only holds or drains.
  `DCA_ASSERT(a_load_no_result,
    (item_fire && item_r.opcode == dca_pkg::OP_LOAD) |=>
      (out_vld_r == ($past(out_vld_r) && !$past(out_ready))))
  // Input stalls only behind a held item blocked by a full, unread result.
  `DCA_ASSERT(a_stall_cause, !in_ready |-> (item_vld_r && out_vld_r && !out_ready))
  // Both valid flags are clear right after reset.
  `DCA_ASSERT_RST(a_reset_clear, !$past(rst_n) |-> (!item_vld_r && !out_vld_r))

endmodule
`default_nettype wire
